/* hdl/mft_pkg.sv */
// Shared constants and types for the motor feedback multi-turn tracker.
`default_nettype none
package mft_pkg;

  localparam int DEFAULT_NUM_MOTORS = 4;
  localparam int MOTOR_IDX_W = 3;  // wide enough for the largest supported motor count
  localparam int QUEUE_DEPTH = 2;

  localparam logic [10:0] BASE_ID_RESET = 11'd513;

  localparam logic [16:0] JUMP_LIMIT = 17'd4096;
  localparam logic [15:0] HIGH_ZONE = 16'd6500;
  localparam logic [15:0] LOW_ZONE = 16'd1000;

  localparam logic signed [15:0] TURN_MIN = 16'sh8000;
  localparam logic signed [15:0] TURN_MAX = 16'sh7FFF;

  localparam logic signed [30:0] POS_MAX = 31'sd268410879;
  localparam logic signed [30:0] POS_MIN = -31'sd268410879;

  localparam logic OP_FEEDBACK = 1'b0;
  localparam logic OP_CAPTURE = 1'b1;

  // One classified item held between the front and the back.
  typedef struct packed {
    logic                   capture;
    logic [MOTOR_IDX_W-1:0] idx;
    logic [15:0]            angle;
    logic [15:0]            speed;
    logic [15:0]            current;
  } mft_item_t;

endpackage
`default_nettype wire

/* hdl/motor_feedback_multiturn_tracker.sv */
// Top level: multi-turn position tracker for motors reporting over CAN feedback frames.
// Throughput is one item per cycle; in_ready drops only when the two-entry queue is full.
// A frame's result passes through the queue, then the state update into stage A, then
// the position add and saturation into the output register.
// Items that match no motor, and capture-zero commands, produce no result.
// Synchronous active-high reset sets base_id to 513 and clears all angles, turns and offsets.
`default_nettype none
module motor_feedback_multiturn_tracker import mft_pkg::*; #(
  parameter int NUM_MOTORS = DEFAULT_NUM_MOTORS
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_write,
  input  wire logic [10:0] cfg_data,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        operation,
  input  wire logic [10:0] frame_id,
  input  wire logic [15:0] angle_word,
  input  wire logic [15:0] speed_word,
  input  wire logic [15:0] current_word,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [1:0]       motor_index,
  output logic signed [15:0] turns,
  output logic signed [28:0] position,
  output logic [15:0]      speed_out,
  output logic [15:0]      current_out
);

  // The front end classifies each accepted item. Frames for unknown identifiers are
  // dropped right there, so they never occupy the queue.
  logic      push;
  mft_item_t push_item;
  logic      q_full;

  // The back end drains the queue in order, so a capture always sees the angles
  // left by every frame accepted before it.
  logic      q_pop;
  logic      q_not_empty;
  mft_item_t q_head;

  mft_front #(
    .NUM_MOTORS(NUM_MOTORS)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg_write   (cfg_write),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .operation   (operation),
    .frame_id    (frame_id),
    .angle_word  (angle_word),
    .speed_word  (speed_word),
    .current_word(current_word),
    .q_full      (q_full),
    .push        (push),
    .item        (push_item)
  );

  mft_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_item(push_item),
    .full     (q_full),
    .pop      (q_pop),
    .not_empty(q_not_empty),
    .head     (q_head)
  );

  // Two registered stages in the back end: state update, then the position sum.
  // The output register holds a result until it is taken; a full stage A then waits too.
  mft_back #(
    .NUM_MOTORS(NUM_MOTORS)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .q_not_empty(q_not_empty),
    .q_head     (q_head),
    .q_pop      (q_pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .motor_index(motor_index),
    .turns      (turns),
    .position   (position),
    .speed_out  (speed_out),
    .current_out(current_out)
  );

endmodule
`default_nettype wire

/* hdl/mft_front.sv */
// Front end: holds base_id, accepts items and keeps only those that do work.
`default_nettype none
module mft_front import mft_pkg::*; #(
  parameter int NUM_MOTORS = DEFAULT_NUM_MOTORS
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_write,
  input  wire logic [10:0] cfg_data,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        operation,
  input  wire logic [10:0] frame_id,
  input  wire logic [15:0] angle_word,
  input  wire logic [15:0] speed_word,
  input  wire logic [15:0] current_word,
  input  wire logic        q_full,
  output logic             push,
  output mft_item_t        item
);

  localparam logic [10:0] NUM_ID = 11'(NUM_MOTORS);

  logic [10:0] base_id;
  logic [10:0] id_delta;
  logic        id_match;

  always_ff @(posedge clk) begin
    if (rst) begin
      base_id <= BASE_ID_RESET;
    end else if (cfg_write) begin
      base_id <= cfg_data;
    end
  end

  // Identifiers do not wrap: the frame must lie at or above base_id.
  assign id_delta = frame_id - base_id;
  assign id_match = (frame_id >= base_id) && (id_delta < NUM_ID);

  assign in_ready = !q_full;
  assign push = in_valid && in_ready && ((operation == OP_CAPTURE) || id_match);

  always_comb begin
    item.capture = (operation == OP_CAPTURE);
    item.idx     = id_delta[MOTOR_IDX_W-1:0];
    item.angle   = angle_word;
    item.speed   = speed_word;
    item.current = current_word;
  end

endmodule
`default_nettype wire

/* hdl/mft_queue.sv */
// Two-entry queue that decouples the front end from the back end.
`default_nettype none
module mft_queue import mft_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      push,
  input  wire mft_item_t push_item,
  output logic           full,
  input  wire logic      pop,
  output logic           not_empty,
  output mft_item_t      head
);

  mft_item_t  slots [QUEUE_DEPTH];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign full = (count == 2'(QUEUE_DEPTH));
  assign not_empty = (count != 2'd0);
  assign head = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule
`default_nettype wire

/* hdl/mft_back.sv */
// Back end: per-motor state update, then position arithmetic into the output register.
`default_nettype none
module mft_back import mft_pkg::*; #(
  parameter int NUM_MOTORS = DEFAULT_NUM_MOTORS
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               q_not_empty,
  input  wire mft_item_t          q_head,
  output logic                    q_pop,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [1:0]              motor_index,
  output logic signed [15:0]      turns,
  output logic signed [28:0]      position,
  output logic [15:0]             speed_out,
  output logic [15:0]             current_out
);

  localparam int IDX_W = (NUM_MOTORS > 1) ? $clog2(NUM_MOTORS) : 1;

  logic [15:0]        angle_prev  [NUM_MOTORS];
  logic signed [15:0] turn_count  [NUM_MOTORS];
  logic [15:0]        zero_offset [NUM_MOTORS];

  // Stage A holds the updated motor state, stage B is the output register.
  logic               a_valid;
  logic [MOTOR_IDX_W-1:0] a_idx;
  logic signed [15:0] a_turns;
  logic [15:0]        a_angle;
  logic [15:0]        a_offset;
  logic [15:0]        a_speed;
  logic [15:0]        a_current;

  logic a_ready;
  logic b_ready;
  logic pop_frame;
  logic pop_capture;

  logic [IDX_W-1:0]   m;
  logic [15:0]        old_angle;
  logic [16:0]        diff;
  logic [16:0]        mag;
  logic               jump;
  logic               step_back;
  logic               step_fwd;
  logic signed [15:0] cur_turns;
  logic signed [15:0] new_turns;

  logic signed [30:0] t_ext;
  logic signed [30:0] pos_raw;
  logic signed [30:0] pos_sat;

  assign b_ready = !out_valid || out_ready;
  assign a_ready = !a_valid || b_ready;

  // A capture needs no output slot; a frame waits until stage A can take it.
  assign pop_capture = q_not_empty && q_head.capture;
  assign pop_frame = q_not_empty && !q_head.capture && a_ready;
  assign q_pop = pop_capture || pop_frame;

  assign m = q_head.idx[IDX_W-1:0];
  assign old_angle = angle_prev[m];
  assign cur_turns = turn_count[m];
  assign diff = {1'b0, q_head.angle} - {1'b0, old_angle};
  assign mag = diff[16] ? (17'd0 - diff) : diff;
  assign jump = (mag > JUMP_LIMIT);
  assign step_back = jump && (q_head.angle >= HIGH_ZONE) && (old_angle <= LOW_ZONE);
  assign step_fwd = jump && !step_back && (q_head.angle <= LOW_ZONE) &&
                    (old_angle >= HIGH_ZONE);

  always_comb begin
    new_turns = cur_turns;
    if (step_back && (cur_turns != TURN_MIN)) begin
      new_turns = cur_turns - 16'sd1;
    end else if (step_fwd && (cur_turns != TURN_MAX)) begin
      new_turns = cur_turns + 16'sd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < NUM_MOTORS; k++) begin
        angle_prev[k]  <= 16'd0;
        turn_count[k]  <= 16'sd0;
        zero_offset[k] <= 16'd0;
      end
    end else if (pop_capture) begin
      for (int k = 0; k < NUM_MOTORS; k++) begin
        zero_offset[k] <= angle_prev[k];
      end
    end else if (pop_frame) begin
      angle_prev[m] <= q_head.angle;
      turn_count[m] <= new_turns;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (pop_frame) begin
      a_valid <= 1'b1;
    end else if (b_ready) begin
      a_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop_frame) begin
      a_idx     <= q_head.idx;
      a_turns   <= new_turns;
      a_angle   <= q_head.angle;
      a_offset  <= zero_offset[m];
      a_speed   <= q_head.speed;
      a_current <= q_head.current;
    end
  end

  // 8191 * turns is formed as turns * 8192 - turns.
  assign t_ext = 31'(a_turns);
  assign pos_raw = (t_ext <<< 13) - t_ext + $signed({15'd0, a_angle}) -
                   $signed({15'd0, a_offset});

  always_comb begin
    pos_sat = pos_raw;
    if (pos_raw > POS_MAX) begin
      pos_sat = POS_MAX;
    end else if (pos_raw < POS_MIN) begin
      pos_sat = POS_MIN;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (b_ready) begin
      out_valid <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (b_ready && a_valid) begin
      motor_index <= a_idx[1:0];
      turns       <= a_turns;
      position    <= pos_sat[28:0];
      speed_out   <= a_speed;
      current_out <= a_current;
    end
  end

endmodule
`default_nettype wire

/* tb/sv/tb_motor_feedback_multiturn_tracker.sv */
// Self-checking testbench for the motor feedback multi-turn tracker.
module tb_motor_feedback_multiturn_tracker;
  import mft_pkg::*;

  localparam int MOTORS = DEFAULT_NUM_MOTORS;
  localparam int TICKS_PER_TURN = 8191;
  localparam int TURN_LO = -32768;
  localparam int TURN_HI = 32767;
  localparam int BACKLOG_LIMIT = 64;
  localparam int SETTLE_CYCLES = 6;
  localparam int RANDOM_CHUNK = 300;
  localparam int SWEEP_WRAPS = 40;

  // One input item as the driver presents it to the block.
  typedef struct {
    logic        op;
    logic [10:0] id;
    logic [15:0] angle;
    logic [15:0] speed;
    logic [15:0] current;
  } feedback_item_t;

  // One position report as the block should emit it.
  typedef struct {
    logic [1:0]         motor;
    logic signed [15:0] turns;
    logic signed [28:0] pos;
    logic [15:0]        speed;
    logic [15:0]        current;
  } motor_report_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_write = 1'b0;
  logic [10:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic operation = OP_FEEDBACK;
  logic [10:0] frame_id = '0;
  logic [15:0] angle_word = '0;
  logic [15:0] speed_word = '0;
  logic [15:0] current_word = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [1:0] motor_index;
  logic signed [15:0] turns;
  logic signed [28:0] position;
  logic [15:0] speed_out;
  logic [15:0] current_out;

  motor_feedback_multiturn_tracker #(
    .NUM_MOTORS(MOTORS)
  ) dut (
    .clk(clk),
    .rst(rst),
    .cfg_write(cfg_write),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .operation(operation),
    .frame_id(frame_id),
    .angle_word(angle_word),
    .speed_word(speed_word),
    .current_word(current_word),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .motor_index(motor_index),
    .turns(turns),
    .position(position),
    .speed_out(speed_out),
    .current_out(current_out)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Items waiting for the driver, and reports waiting for the block to produce them.
  feedback_item_t frame_backlog[$];
  motor_report_t pending_reports[$];

  // Our own copy of the tracker state: base identifier and per-motor registers.
  logic [10:0] base_model = BASE_ID_RESET;
  logic [15:0] last_angle[MOTORS];
  int          turn_total[MOTORS];
  logic [15:0] zero_point[MOTORS];

  int frames_accepted = 0;
  int captures_seen = 0;
  int reports_checked = 0;
  int mismatches = 0;
  int base_writes = 0;

  // When set, both sides run flat out; used for the turn-count sweeps.
  bit sweep_mode = 1'b0;

  initial begin
    for (int k = 0; k < MOTORS; k++) begin
      last_angle[k] = '0;
      turn_total[k] = 0;
      zero_point[k] = '0;
    end
  end

  // Apply one accepted item to the state copy. A capture copies every motor's last
  // angle into its zero point. A frame for one of our motors steps the turn count
  // when the angle crossed the wrap, then queues the expected position report.
  task automatic track_feedback(input logic op, input logic [10:0] id,
                                input logic [15:0] ang, input logic [15:0] spd,
                                input logic [15:0] cur);
    int rel;
    int old_angle;
    int jump;
    longint sum;
    motor_report_t rep;
    if (op == OP_CAPTURE) begin
      for (int k = 0; k < MOTORS; k++) zero_point[k] = last_angle[k];
      captures_seen++;
      return;
    end
    // Identifiers do not wrap: an id below the base, or past the last motor, is ignored.
    rel = int'(id) - int'(base_model);
    if (rel < 0 || rel >= MOTORS) return;
    old_angle = int'(last_angle[rel]);
    last_angle[rel] = ang;
    jump = int'(ang) - old_angle;
    if (jump < 0) jump = -jump;
    if (jump > int'(JUMP_LIMIT)) begin
      if (int'(ang) >= int'(HIGH_ZONE) && old_angle <= int'(LOW_ZONE)) begin
        // Went backward through the wrap.
        if (turn_total[rel] > TURN_LO) turn_total[rel]--;
      end else if (int'(ang) <= int'(LOW_ZONE) && old_angle >= int'(HIGH_ZONE)) begin
        // Went forward through the wrap.
        if (turn_total[rel] < TURN_HI) turn_total[rel]++;
      end
    end
    sum = longint'(TICKS_PER_TURN) * turn_total[rel] + longint'(ang)
          - longint'(zero_point[rel]);
    // Angles above one turn can push the sum outside the position range.
    if (sum > longint'(POS_MAX)) sum = longint'(POS_MAX);
    if (sum < longint'(POS_MIN)) sum = longint'(POS_MIN);
    rep.motor = rel[1:0];
    rep.turns = turn_total[rel][15:0];
    rep.pos = sum[28:0];
    rep.speed = spd;
    rep.current = cur;
    pending_reports.push_back(rep);
  endtask

  // Sender: idles with gaps that are mostly short, sometimes long, with bursts of none.
  int gap_left = 0;
  int send_burst = 0;
  feedback_item_t next_frame;

  function automatic int pick_gap();
    int r;
    if (sweep_mode) return 0;
    if (send_burst > 0) begin
      send_burst--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 2) begin
      send_burst = $urandom_range(20, 80);
      return 0;
    end
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // The driver moves to the next item only once the current one is taken, so valid
  // and the payload hold steady while the block is stalled.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      gap_left = 0;
    end else if (!in_valid || in_ready) begin
      if (in_valid) begin
        track_feedback(operation, frame_id, angle_word, speed_word, current_word);
        frames_accepted++;
      end
      if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (frame_backlog.size() != 0) begin
        next_frame = frame_backlog.pop_front();
        operation <= next_frame.op;
        frame_id <= next_frame.id;
        angle_word <= next_frame.angle;
        speed_word <= next_frame.speed;
        current_word <= next_frame.current;
        in_valid <= 1'b1;
        gap_left = pick_gap();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: random back-pressure, occasional long holds, and one forced long hold
  // early in the random part so the block's queue fills and in_ready drops.
  int hold_left = 0;
  int ready_run = 0;
  bit long_hold_done = 1'b0;
  int ready_roll;

  task automatic compare_field(input string name, input longint want, input longint got);
    if (want != got) begin
      mismatches++;
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin
    motor_report_t rep;
    if (rst) begin
      out_ready <= 1'b0;
      hold_left = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (pending_reports.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected report: expected none, actual motor %0d position %0d",
                   $time, motor_index, position);
        end else begin
          rep = pending_reports.pop_front();
          compare_field("motor_index", longint'(rep.motor), longint'(motor_index));
          compare_field("turns", longint'(rep.turns), longint'(turns));
          compare_field("position", longint'(rep.pos), longint'(position));
          compare_field("speed_out", longint'(rep.speed), longint'(speed_out));
          compare_field("current_out", longint'(rep.current), longint'(current_out));
        end
        reports_checked++;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (!long_hold_done && reports_checked >= 60) begin
        long_hold_done = 1'b1;
        hold_left = 200;
        out_ready <= 1'b0;
      end else if (sweep_mode) begin
        out_ready <= 1'b1;
      end else if (ready_run > 0) begin
        ready_run--;
        out_ready <= 1'b1;
      end else begin
        ready_roll = $urandom_range(0, 999);
        if (ready_roll < 4) begin
          hold_left = $urandom_range(30, 120);
          out_ready <= 1'b0;
        end else if (ready_roll < 20) begin
          ready_run = $urandom_range(20, 80);
          out_ready <= 1'b1;
        end else begin
          out_ready <= ($urandom_range(0, 99) < 70);
        end
      end
    end
  end

  function automatic feedback_item_t make_frame(input logic op, input logic [10:0] id,
                                                input logic [15:0] ang,
                                                input logic [15:0] spd,
                                                input logic [15:0] cur);
    feedback_item_t it;
    it.op = op;
    it.id = id;
    it.angle = ang;
    it.speed = spd;
    it.current = cur;
    return it;
  endfunction

  // Items are added on the falling edge so the driver never races the queue.
  task automatic queue_frame(input feedback_item_t it);
    while (frame_backlog.size() >= BACKLOG_LIMIT) @(negedge clk);
    frame_backlog.push_back(it);
  endtask

  task automatic queue_angle(input int motor, input logic [15:0] ang);
    queue_frame(make_frame(OP_FEEDBACK, base_model + 11'(motor), ang,
                           16'($urandom), 16'($urandom)));
  endtask

  task automatic queue_capture();
    queue_frame(make_frame(OP_CAPTURE, 11'($urandom), 16'($urandom), 16'($urandom),
                           16'($urandom)));
  endtask

  // The sender stops until every report has come back, then allows for items still
  // inside the block that produce no report.
  task automatic wait_until_idle();
    do @(negedge clk);
    while (frame_backlog.size() != 0 || in_valid || pending_reports.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_base_id(input logic [10:0] value);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_data <= value;
    base_model = value;
    base_writes++;
    @(posedge clk);
    cfg_write <= 1'b0;
    @(negedge clk);
  endtask

  // Mostly frames for our own motors, with angles clustered around the wrap zones so
  // that turn steps are frequent; the rest are captures and stray identifiers.
  function automatic feedback_item_t random_frame();
    feedback_item_t it;
    int pick;
    it.op = OP_FEEDBACK;
    it.speed = 16'($urandom);
    it.current = 16'($urandom);
    if ($urandom_range(0, 19) == 0) it.speed = ($urandom_range(0, 1) != 0) ? 16'hFFFF : 16'h0;
    if ($urandom_range(0, 19) == 0) it.current = ($urandom_range(0, 1) != 0) ? 16'hFFFF : 16'h0;
    pick = $urandom_range(0, 99);
    if (pick < 35) it.angle = 16'($urandom_range(0, int'(LOW_ZONE)));
    else if (pick < 70) it.angle = 16'($urandom_range(int'(HIGH_ZONE), TICKS_PER_TURN));
    else if (pick < 90) it.angle = 16'($urandom_range(int'(LOW_ZONE) + 1, int'(HIGH_ZONE) - 1));
    else it.angle = 16'($urandom);
    pick = $urandom_range(0, 99);
    if (pick < 5) begin
      it.op = OP_CAPTURE;
      it.id = 11'($urandom);
    end else if (pick < 13) begin
      case ($urandom_range(0, 2))
        0: it.id = base_model - 11'd1;
        1: it.id = base_model + 11'(MOTORS);
        default: it.id = 11'($urandom);
      endcase
    end else begin
      it.id = base_model + 11'($urandom_range(0, MOTORS - 1));
    end
    return it;
  endfunction

  initial begin
    logic [10:0] random_bases[5];

    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed part at the reset base identifier: wrap steps in both directions, the
    // zone boundaries, a large jump that is no wrap, stray identifiers on both sides
    // of the range, a capture, and the widest angle, speed and current words.
    queue_frame(make_frame(OP_FEEDBACK, 11'd513, 16'd0, 16'h0000, 16'h0000));
    queue_frame(make_frame(OP_FEEDBACK, 11'd513, 16'd7000, 16'hFFFF, 16'hFFFF));
    queue_frame(make_frame(OP_FEEDBACK, 11'd513, 16'd500, 16'h5555, 16'hAAAA));
    queue_frame(make_frame(OP_FEEDBACK, 11'd513, 16'd8191, 16'hAAAA, 16'h5555));
    queue_frame(make_frame(OP_FEEDBACK, 11'd513, 16'd0, 16'h1234, 16'h8000));
    queue_frame(make_frame(OP_FEEDBACK, 11'd514, 16'd5000, 16'h0001, 16'h7FFF));
    queue_frame(make_frame(OP_FEEDBACK, 11'd514, 16'd1001, 16'h8000, 16'h0001));
    queue_frame(make_frame(OP_FEEDBACK, 11'd515, 16'd1000, 16'h0, 16'hFFFF));
    queue_frame(make_frame(OP_FEEDBACK, 11'd515, 16'd6500, 16'hFFFF, 16'h0));
    queue_frame(make_frame(OP_FEEDBACK, 11'd515, 16'd1000, 16'h00FF, 16'hFF00));
    queue_frame(make_frame(OP_FEEDBACK, 11'd516, 16'd1001, 16'hFF00, 16'h00FF));
    queue_frame(make_frame(OP_FEEDBACK, 11'd516, 16'd6500, 16'h0F0F, 16'hF0F0));
    queue_frame(make_frame(OP_FEEDBACK, 11'd516, 16'hFFFF, 16'hF0F0, 16'h0F0F));
    queue_frame(make_frame(OP_FEEDBACK, 11'd512, 16'd7000, 16'h1, 16'h1));
    queue_frame(make_frame(OP_FEEDBACK, 11'd517, 16'd7000, 16'h2, 16'h2));
    queue_frame(make_frame(OP_FEEDBACK, 11'd2047, 16'd7000, 16'h3, 16'h3));
    queue_frame(make_frame(OP_FEEDBACK, 11'd0, 16'd7000, 16'h4, 16'h4));
    queue_frame(make_frame(OP_CAPTURE, 11'd513, 16'hFFFF, 16'hFFFF, 16'hFFFF));
    queue_frame(make_frame(OP_FEEDBACK, 11'd516, 16'd0, 16'h6, 16'h6));
    queue_frame(make_frame(OP_FEEDBACK, 11'd513, 16'd4000, 16'h7, 16'h7));
    wait_until_idle();

    // Range at the top of the identifier space: only three motors exist.
    write_base_id(11'd2045);
    queue_frame(make_frame(OP_FEEDBACK, 11'd2045, 16'd100, 16'h8, 16'h8));
    queue_frame(make_frame(OP_FEEDBACK, 11'd2047, 16'd200, 16'h9, 16'h9));
    queue_frame(make_frame(OP_FEEDBACK, 11'd2044, 16'd300, 16'hA, 16'hA));
    queue_frame(make_frame(OP_FEEDBACK, 11'd0, 16'd400, 16'hB, 16'hB));
    wait_until_idle();

    // Range at the bottom of the identifier space.
    write_base_id(11'd0);
    queue_frame(make_frame(OP_FEEDBACK, 11'd0, 16'd7000, 16'hC, 16'hC));
    queue_frame(make_frame(OP_FEEDBACK, 11'd3, 16'd900, 16'hD, 16'hD));
    queue_frame(make_frame(OP_FEEDBACK, 11'd4, 16'd900, 16'hE, 16'hE));
    wait_until_idle();

    // Random part, one chunk per base identifier setting, extremes included.
    random_bases[0] = 11'($urandom_range(0, 2047));
    random_bases[1] = 11'd2047;
    random_bases[2] = 11'd0;
    random_bases[3] = 11'd2044;
    random_bases[4] = BASE_ID_RESET;
    foreach (random_bases[b]) begin
      write_base_id(random_bases[b]);
      repeat (RANDOM_CHUNK) queue_frame(random_frame());
      wait_until_idle();
    end

    // Turn-count runs. First park every motor near zero with no turn step and clear
    // the zero points, then step one motor forward and another backward through the
    // wrap many times in a row, one wrap per three frames.
    sweep_mode = 1'b1;
    for (int k = 0; k < MOTORS; k++) begin
      queue_angle(k, 16'd3000);
      queue_angle(k, 16'd0);
    end
    queue_capture();
    wait_until_idle();

    repeat (SWEEP_WRAPS) begin
      queue_angle(1, 16'd4000);
      queue_angle(1, 16'd7000);
      queue_angle(1, 16'd500);
    end
    // An angle word of all ones, far above one turn, goes straight into the sum.
    queue_angle(1, 16'd4000);
    queue_angle(1, 16'd7000);
    queue_angle(1, 16'hFFFF);
    wait_until_idle();

    repeat (SWEEP_WRAPS) begin
      queue_angle(2, 16'd7000);
      queue_angle(2, 16'd3000);
      queue_angle(2, 16'd500);
    end
    // One more backward step, then a large zero point taken from the all-ones angle.
    queue_angle(2, 16'hFFFF);
    queue_capture();
    queue_angle(2, 16'd0);
    wait_until_idle();
    sweep_mode = 1'b0;

    $display("Run covered %0d items (%0d captures) over %0d base identifier writes,",
             frames_accepted, captures_seen, base_writes);
    $display("checked %0d position reports, including long runs of turn steps.",
             reports_checked);
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // Generous bound: even with the longest gaps and holds on every item the run ends
  // well inside this timeout.
  initial begin
    #32000000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
